FILE: sv/ott_pkg.sv
// ott_pkg: shared types and codes for the ordered task table
// used by ott_cell and ordered_task_table; no dependencies
package ott_pkg;

   typedef enum logic [3:0] {
      REQ_INSERT  = 4'd0,
      REQ_DELETE  = 4'd1,
      REQ_LOOKUP  = 4'd2,
      REQ_SET_ST  = 4'd3,
      REQ_SET_PR  = 4'd4,
      REQ_SET_RUN = 4'd5,
      REQ_SET_KND = 4'd6,
      REQ_SET_REL = 4'd7,
      REQ_UPDATE  = 4'd8,
      REQ_COUNT   = 4'd9
   } req_code_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_IGNORED   = 2'd3;

   localparam logic [2:0] STATE_READY     = 3'd0;
   localparam logic [2:0] STATE_SUSPENDED = 3'd1;
   localparam logic [2:0] STATE_DELETED   = 3'd2;
   localparam logic [2:0] KIND_INSTANT    = 3'd0;
   localparam logic [2:0] KIND_PERIODIC   = 3'd1;
   localparam logic [2:0] KIND_UNLIM      = 3'd2;
   localparam logic [2:0] KIND_NONE       = 3'd7;

   // per-cell operation broadcast from the controller
   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_LOAD    = 3'd1,
      OP_SHIFT_R = 3'd2,
      OP_SHIFT_L = 3'd3,
      OP_FIELD   = 3'd4
   } cell_op_type;

   typedef struct packed {
      logic [7:0] id;
      logic [2:0] kind;
      logic [2:0] state;
      logic [7:0] prio;
      logic [7:0] base;
   } rec_small_type;

endpackage

FILE: sv/ott_cell.sv
// ott_cell: one slot of the task list, shifts records to its neighbors
// depends on ott_pkg
module ott_cell #(
   parameter int TB = 32
) (
   input  logic                    clock,
   input  ott_pkg::cell_op_type    op,
   input  logic                    sel,
   input  logic [3:0]              field_req,
   input  ott_pkg::rec_small_type  new_rec,
   input  logic [TB-1:0]           new_run,
   input  logic [TB-1:0]           new_rel,
   input  ott_pkg::rec_small_type  left_rec,
   input  logic [TB-1:0]           left_run,
   input  logic [TB-1:0]           left_rel,
   input  ott_pkg::rec_small_type  right_rec,
   input  logic [TB-1:0]           right_run,
   input  logic [TB-1:0]           right_rel,
   input  logic [7:0]              key,
   output logic                    match,
   output ott_pkg::rec_small_type  rec,
   output logic [TB-1:0]           run,
   output logic [TB-1:0]           rel
);

   ott_pkg::rec_small_type rec_ff, rec_in;
   logic [TB-1:0] run_ff, run_in, rel_ff, rel_in;

   // next record of this slot
   always_comb begin
      rec_in = rec_ff;
      run_in = run_ff;
      rel_in = rel_ff;
      if (sel) begin
         case (op)
            ott_pkg::OP_LOAD: begin
               rec_in = new_rec;
               run_in = new_run;
               rel_in = new_rel;
            end
            ott_pkg::OP_SHIFT_R: begin
               rec_in = left_rec;
               run_in = left_run;
               rel_in = left_rel;
            end
            ott_pkg::OP_SHIFT_L: begin
               rec_in = right_rec;
               run_in = right_run;
               rel_in = right_rel;
            end
            ott_pkg::OP_FIELD: begin
               case (field_req)
                  ott_pkg::REQ_SET_ST:  rec_in.state = new_rec.state;
                  ott_pkg::REQ_SET_PR:  rec_in.prio = new_rec.prio;
                  ott_pkg::REQ_SET_RUN: run_in = new_run;
                  ott_pkg::REQ_SET_KND: rec_in.kind = new_rec.kind;
                  ott_pkg::REQ_SET_REL: rel_in = new_rel;
                  ott_pkg::REQ_UPDATE: begin
                     rec_in.kind = new_rec.kind;
                     rec_in.prio = new_rec.prio;
                     run_in = new_run;
                     rel_in = new_rel;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      run_ff <= run_in;
      rel_ff <= rel_in;
   end

   assign match = (rec_ff.id == key);
   assign rec   = rec_ff;
   assign run   = run_ff;
   assign rel   = rel_ff;

endmodule

FILE: sv/ordered_task_table.sv
// ordered_task_table: top level, controller over a chain of ott_cell slots
// depends on ott_pkg and ott_cell
//
// An ordered list of up to MAX_TASKS task records held in a row of cells.
// The request beat is registered first. Then, in S_EXEC, the cells compare
// the id in parallel and a priority pick finds the first match. In the
// same cycle the cells shift by one slot (insert or delete) or the matched
// cell writes its fields, and the result beat is formed in the rsp register.
// A new request is taken only while the controller is idle and the result
// register is free or being emptied, so a request is not taken until the
// one before it has executed. Record storage has no reset; only the count,
// the state and the result valid clear.
module ordered_task_table #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // req_type[3:0], position[8:4], task_id[16:9], task_kind[19:17],
   // prio_value[27:20], run_time[59:28], release_at[91:60], new_state[94:92]
   input  logic [95:0]   req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], found_pos[6:2], cur_state[9:7], cur_priority[17:10],
   // base_prio[25:18], run_time_out[57:26], kind_out[60:58],
   // release_out[92:61], task_count[97:93]
   output logic [103:0]  rsp_tdata
);

   localparam int IW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int TB = TIME_BITS;

   typedef enum logic [0:0] {S_IDLE, S_EXEC} fsm_type;

   fsm_type fsm_ff;
   logic [95:0] req_ff;
   logic [CW-1:0] count_ff;
   logic rsp_valid_ff;
   logic [103:0] rsp_data_ff;

   // request fields
   logic [3:0] r_type;
   logic [4:0] r_pos;
   logic [7:0] r_id;
   logic [2:0] r_kind, r_nstate;
   logic [7:0] r_prio;
   logic [31:0] r_run, r_rel;
   assign r_type   = req_ff[3:0];
   assign r_pos    = req_ff[8:4];
   assign r_id     = req_ff[16:9];
   assign r_kind   = req_ff[19:17];
   assign r_prio   = req_ff[27:20];
   assign r_run    = req_ff[59:28];
   assign r_rel    = req_ff[91:60];
   assign r_nstate = req_ff[94:92];

   // cell chain
   ott_pkg::rec_small_type recs [MAX_TASKS];
   logic [TB-1:0] runs [MAX_TASKS];
   logic [TB-1:0] rels [MAX_TASKS];
   logic [MAX_TASKS-1:0] match_raw, sel;
   ott_pkg::cell_op_type op;
   ott_pkg::rec_small_type new_rec;
   logic [TB-1:0] new_run, new_rel;

   // hit search: first matching slot below count
   logic hit;
   logic [IW-1:0] hit_idx;
   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (match_raw[i] && (CW'(i) < count_ff)) begin
            hit = 1'b1;
            hit_idx = IW'(i);
         end
      end
   end

   // decode of the held request
   logic is_search, ins_ok, del_one, del_ok;
   logic [CW-1:0] at_pos, del_at;
   logic [CW:0] pos_w;
   always_comb begin
      pos_w = (CW+1)'(r_pos);
      is_search = (r_type >= 4'(ott_pkg::REQ_LOOKUP)) &&
                  (r_type <= 4'(ott_pkg::REQ_UPDATE));
      ins_ok = (r_type == 4'(ott_pkg::REQ_INSERT)) &&
               (count_ff < CW'(MAX_TASKS)) &&
               !(r_pos == 5'd0 && count_ff != '0);
      if (count_ff == '0) at_pos = '0;
      else if (pos_w - 1'b1 > (CW+1)'(count_ff)) at_pos = count_ff;
      else at_pos = CW'(pos_w - 1'b1);
      del_one = (r_type == 4'(ott_pkg::REQ_DELETE)) && (count_ff == CW'(1));
      del_ok = (r_type == 4'(ott_pkg::REQ_DELETE)) && (count_ff > CW'(1)) &&
               (r_pos != 5'd0) && (pos_w <= (CW+1)'(count_ff));
      del_at = CW'(pos_w - 1'b1);
   end

   // new record for load or field write
   always_comb begin
      new_rec.id    = r_id;
      new_rec.kind  = r_kind;
      new_rec.state = (r_type == 4'(ott_pkg::REQ_SET_ST)) ? r_nstate :
                      ((r_kind == ott_pkg::KIND_INSTANT) ?
                       ott_pkg::STATE_SUSPENDED : ott_pkg::STATE_READY);
      new_rec.prio  = r_prio;
      new_rec.base  = r_prio;
      new_run = TB'({32'd0, r_run});
      new_rel = (r_type == 4'(ott_pkg::REQ_INSERT) &&
                 !(r_kind == ott_pkg::KIND_PERIODIC || r_kind == ott_pkg::KIND_UNLIM))
                ? '0 : TB'({32'd0, r_rel});
   end

   // per-cell selects; insert shifts right above at_pos, delete shifts left
   logic exec;
   assign exec = (fsm_ff == S_EXEC);
   always_comb begin
      op = ott_pkg::OP_HOLD;
      if (exec) begin
         if (ins_ok) op = ott_pkg::OP_SHIFT_R;
         else if (del_ok) op = ott_pkg::OP_SHIFT_L;
         else if (is_search && hit) op = ott_pkg::OP_FIELD;
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         ott_pkg::cell_op_type c_op;
         logic c_sel;
         always_comb begin
            c_op = op;
            c_sel = 1'b0;
            case (op)
               ott_pkg::OP_SHIFT_R: begin
                  if (CW'(g) == at_pos) begin
                     c_op = ott_pkg::OP_LOAD;
                     c_sel = 1'b1;
                  end else c_sel = (CW'(g) > at_pos) && (CW'(g) <= count_ff);
               end
               ott_pkg::OP_SHIFT_L:
                  c_sel = (CW'(g) >= del_at) && (CW'(g) + 1'b1 < count_ff);
               ott_pkg::OP_FIELD: c_sel = (IW'(g) == hit_idx);
               default: c_sel = 1'b0;
            endcase
         end
         assign sel[g] = c_sel;
         ott_cell #(.TB(TB)) u_cell (
            .clock     (clock),
            .op        (c_op),
            .sel       (c_sel),
            .field_req (r_type),
            .new_rec   (new_rec),
            .new_run   (new_run),
            .new_rel   (new_rel),
            .left_rec  (recs[(g == 0) ? 0 : g - 1]),
            .left_run  (runs[(g == 0) ? 0 : g - 1]),
            .left_rel  (rels[(g == 0) ? 0 : g - 1]),
            .right_rec (recs[(g == MAX_TASKS - 1) ? g : g + 1]),
            .right_run (runs[(g == MAX_TASKS - 1) ? g : g + 1]),
            .right_rel (rels[(g == MAX_TASKS - 1) ? g : g + 1]),
            .key       (r_id),
            .match     (match_raw[g]),
            .rec       (recs[g]),
            .run       (runs[g]),
            .rel       (rels[g])
         );
      end
   endgenerate

   // result fields, with the matched record after its update
   logic [1:0] st;
   logic [CW-1:0] cnt_next;
   ott_pkg::rec_small_type hr;
   logic [TB-1:0] hrun, hrel;
   logic [103:0] rsp_data_in;
   always_comb begin
      st = ott_pkg::ST_OK;
      cnt_next = count_ff;
      if (r_type == 4'(ott_pkg::REQ_INSERT)) begin
         if (count_ff >= CW'(MAX_TASKS)) st = ott_pkg::ST_FULL;
         else if (!ins_ok) st = ott_pkg::ST_IGNORED;
         else cnt_next = count_ff + 1'b1;
      end else if (r_type == 4'(ott_pkg::REQ_DELETE)) begin
         if (del_one || del_ok) cnt_next = count_ff - 1'b1;
         else st = ott_pkg::ST_IGNORED;
      end else if (is_search) begin
         if (!hit) st = ott_pkg::ST_NOT_FOUND;
      end else if (r_type != 4'(ott_pkg::REQ_COUNT)) begin
         st = ott_pkg::ST_IGNORED;
      end
      hr = recs[hit_idx];
      hrun = runs[hit_idx];
      hrel = rels[hit_idx];
      case (r_type)
         ott_pkg::REQ_SET_ST:  hr.state = r_nstate;
         ott_pkg::REQ_SET_PR:  hr.prio = r_prio;
         ott_pkg::REQ_SET_RUN: hrun = new_run;
         ott_pkg::REQ_SET_KND: hr.kind = r_kind;
         ott_pkg::REQ_SET_REL: hrel = new_rel;
         ott_pkg::REQ_UPDATE: begin
            hr.kind = r_kind;
            hr.prio = r_prio;
            hrun = new_run;
            hrel = new_rel;
         end
         default: ;
      endcase
      rsp_data_in = '0;
      rsp_data_in[1:0] = st;
      rsp_data_in[97:93] = 5'(cnt_next);
      if (is_search && hit) begin
         rsp_data_in[6:2]   = 5'(hit_idx) + 5'd1;
         rsp_data_in[9:7]   = hr.state;
         rsp_data_in[17:10] = hr.prio;
         rsp_data_in[25:18] = hr.base;
         rsp_data_in[57:26] = 32'({{(64-TB){1'b0}}, hrun});
         rsp_data_in[60:58] = hr.kind;
         rsp_data_in[92:61] = 32'({{(64-TB){1'b0}}, hrel});
      end else begin
         rsp_data_in[9:7]   = ott_pkg::STATE_DELETED;
         rsp_data_in[60:58] = ott_pkg::KIND_NONE;
      end
   end

   assign req_tready = (fsm_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // controller: take request, then execute and register the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (fsm_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               req_ff <= req_tdata;
               fsm_ff <= S_EXEC;
            end
            S_EXEC: begin
               count_ff <= cnt_next;
               rsp_data_ff <= rsp_data_in;
               rsp_valid_ff <= 1'b1;
               fsm_ff <= S_IDLE;
            end
            default: fsm_ff <= S_IDLE;
         endcase
      end
   end

   // count never exceeds the table
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS)) else $error("count overflow");
   // a result beat follows every execute cycle
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff) else $error("no result after execute");
   // count holds while no request executes
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !exec |=> $stable(count_ff)) else $error("count changed while idle");
   // exactly one cell selected on a field update
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      op == ott_pkg::OP_FIELD |-> $onehot(sel)) else $error("field write select");

endmodule
